### hdl/csvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants for the CSV record tokeniser.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_FIELD_END  = 2'd1;
  localparam logic [1:0] KIND_RECORD_END = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] token_byte;
    logic       run_end;
  } out_t;

  // tokens produced by one input byte
  typedef struct packed {
    logic [1:0] count;
    out_t       tok0;
    out_t       tok1;
  } step_res_t;

endpackage
`default_nettype wire

### hdl/csvt_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_step
// Tokeniser state flags and the per-byte decode into at most two tokens.
// ----------------------------------------------------------------------------
module csvt_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire csvt_pkg::in_t      item,
  output csvt_pkg::step_res_t     res
);

  logic inside_quotes, field_begun, quote_pending, cr_pending, record_has_content;
  logic inside_quotes_next, field_begun_next, quote_pending_next;
  logic cr_pending_next, record_has_content_next;
  logic done;
  logic [7:0] b;
  logic [1:0] cnt;
  csvt_pkg::out_t t0, t1;

  assign b = item.text_byte;

  always_comb begin
    inside_quotes_next      = inside_quotes;
    field_begun_next        = field_begun;
    quote_pending_next      = quote_pending;
    cr_pending_next         = cr_pending;
    record_has_content_next = record_has_content;
    done = 1'b0;
    cnt  = 2'd0;
    t0   = '0;
    t1   = '0;

    // lf straight after an unquoted cr is swallowed
    if (cr_pending) begin
      cr_pending_next = 1'b0;
      if (b == csvt_pkg::CH_LF) begin
        done = 1'b1;
      end
    end

    if (!done && quote_pending) begin
      quote_pending_next = 1'b0;
      if (b == csvt_pkg::CH_QUOTE) begin
        t0 = '{token_kind: csvt_pkg::KIND_DATA, token_byte: b, run_end: 1'b0};
        cnt = 2'd1;
        record_has_content_next = 1'b1;
        done = 1'b1;
      end else begin
        inside_quotes_next = 1'b0;
      end
    end

    // at most one token comes from the byte itself, always into slot 0
    if (!done) begin
      if (inside_quotes_next) begin
        if (b == csvt_pkg::CH_QUOTE) begin
          quote_pending_next = 1'b1;
        end else begin
          t0 = '{token_kind: csvt_pkg::KIND_DATA, token_byte: b, run_end: 1'b0};
          cnt = 2'd1;
          record_has_content_next = 1'b1;
        end
      end else begin
        unique case (b)
          csvt_pkg::CH_QUOTE: begin
            if (!field_begun) begin
              inside_quotes_next = 1'b1;
              field_begun_next   = 1'b1;
            end else begin
              t0 = '{token_kind: csvt_pkg::KIND_DATA, token_byte: b, run_end: 1'b0};
              cnt = 2'd1;
              record_has_content_next = 1'b1;
            end
          end
          csvt_pkg::CH_COMMA: begin
            t0 = '{token_kind: csvt_pkg::KIND_FIELD_END, token_byte: 8'd0, run_end: 1'b0};
            cnt = 2'd1;
            record_has_content_next = 1'b1;
            field_begun_next = 1'b0;
          end
          csvt_pkg::CH_CR, csvt_pkg::CH_LF: begin
            field_begun_next = 1'b0;
            if (record_has_content_next) begin
              t0 = '{token_kind: csvt_pkg::KIND_RECORD_END, token_byte: 8'd0,
                     run_end: 1'b0};
              cnt = 2'd1;
            end
            record_has_content_next = 1'b0;
            cr_pending_next = (b == csvt_pkg::CH_CR);
          end
          default: begin
            t0 = '{token_kind: csvt_pkg::KIND_DATA, token_byte: b, run_end: 1'b0};
            cnt = 2'd1;
            record_has_content_next = 1'b1;
            field_begun_next = 1'b1;
          end
        endcase
      end
    end

    // end of text closes an open record and clears everything
    if (item.final_byte) begin
      if (record_has_content_next) begin
        if (cnt == 2'd0) begin
          t0 = '{token_kind: csvt_pkg::KIND_RECORD_END, token_byte: 8'd0, run_end: 1'b0};
        end else begin
          t1 = '{token_kind: csvt_pkg::KIND_RECORD_END, token_byte: 8'd0, run_end: 1'b0};
        end
        cnt = cnt + 2'd1;
      end
      inside_quotes_next      = 1'b0;
      field_begun_next        = 1'b0;
      quote_pending_next      = 1'b0;
      cr_pending_next         = 1'b0;
      record_has_content_next = 1'b0;
    end

    t0.run_end = (cnt == 2'd1);
    t1.run_end = 1'b1;
  end

  assign res = '{count: cnt, tok0: t0, tok1: t1};

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes      <= 1'b0;
      field_begun        <= 1'b0;
      quote_pending      <= 1'b0;
      cr_pending         <= 1'b0;
      record_has_content <= 1'b0;
    end else if (advance) begin
      inside_quotes      <= inside_quotes_next;
      field_begun        <= field_begun_next;
      quote_pending      <= quote_pending_next;
      cr_pending         <= cr_pending_next;
      record_has_content <= record_has_content_next;
    end
  end

endmodule
`default_nettype wire

### hdl/csvt_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_fifo
// Four-entry token queue, up to two pushes per cycle, one pop to the output.
// ----------------------------------------------------------------------------
module csvt_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire csvt_pkg::step_res_t res,
  output logic                     room,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output csvt_pkg::out_t           out_data
);

  csvt_pkg::out_t entry [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill, fill_next;
  logic [1:0] n_push;
  logic       pop;

  assign n_push    = push ? res.count : 2'd0;
  assign out_valid = (fill != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = entry[rd_ptr];
  // room for a full two-token transaction
  assign room      = (fill <= 3'd2);
  assign fill_next = fill + {1'b0, n_push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entry[wr_ptr] <= res.tok0;
    end
    if (n_push == 2'd2) begin
      entry[wr_ptr + 2'd1] <= res.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      fill   <= fill_next;
    end
  end

endmodule
`default_nettype wire

### hdl/csv_record_tokenizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_record_tokenizer_top
// Streaming CSV tokeniser: text bytes in, data / field end / record end out.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle, unless in_stall is high, into an input
// register; the registered byte is decoded against the quote and line-break flags
// once the output queue has room, and its zero to two tokens go into a four-entry
// output queue. Sustained rate is one byte per cycle while each byte yields at most
// one token and the output is not stalled; the output side moves one token per
// cycle when not stalled, so bytes that yield two tokens (final byte closing a
// record) slow the input. Each token passes the input register, then the queue.
module csv_record_tokenizer_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire csvt_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output csvt_pkg::out_t      out_data
);

  csvt_pkg::in_t       in_q;
  logic                in_q_valid;
  logic                room;
  logic                advance;
  csvt_pkg::step_res_t res;

  assign advance  = in_q_valid && room;
  assign in_stall = in_q_valid && !room;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  csvt_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .res     (res)
  );

  csvt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### hdl/csvt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks on the tokeniser's output stream.
// ----------------------------------------------------------------------------
module csvt_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire csvt_pkg::out_t out_data
);

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("token presented right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled token changed");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind != csvt_pkg::KIND_DATA |->
      out_data.token_byte == 8'd0)
    else $error("non-data token carries a byte");

  // a field end that is not last in its transaction is followed by a record end
  a_fe_then_re: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.token_kind == csvt_pkg::KIND_FIELD_END &&
      !out_data.run_end |=>
      out_valid && out_data.token_kind == csvt_pkg::KIND_RECORD_END && out_data.run_end)
    else $error("field end not followed by record end");

endmodule

bind csv_record_tokenizer_top csvt_checker u_csvt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
